[rtl/ntm_pkg.sv]
// shared types, widths and constants for the nearest track time match block
// no dependencies; every other file in rtl depends on this package
package ntm_pkg;

  localparam int MaxEntries = 256;
  localparam int SlotW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CountW     = $clog2(MaxEntries + 1);

  localparam int CmdW    = 2;
  localparam int EtaW    = 14;
  localparam int PhiW    = 13;
  localparam int TimeW   = 16;
  localparam int ResW    = 16;
  localparam int IndexW  = 8;
  localparam int MaxDistW = 28;
  localparam int CfgW    = 28;
  localparam int CfgIdxW = 1;

  // eta difference, squared terms and their sum
  localparam int DeW   = EtaW + 1;
  localparam int De2W  = 2 * DeW - 1;
  localparam int Dp2W  = 2 * PhiW - 2;
  localparam int D2W   = De2W;

  localparam logic signed [PhiW+1:0] PhiPi    = 15'sd3217;
  localparam logic signed [PhiW+1:0] PhiTwoPi = 15'sd6434;

  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CmdW-1:0] CMD_QUERY = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_MAX_DIST = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DEF_RES  = 1'b1;

  localparam logic [MaxDistW-1:0] MaxDistReset = 28'd10485760;
  localparam logic [ResW-1:0]     DefResReset  = 16'd350;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [EtaW-1:0]  eta;
    logic signed [PhiW-1:0]  phi;
    logic signed [TimeW-1:0] tm;
    logic [ResW-1:0]         resol;
  } entry_t;

  // scan control from the sequencer to the distance unit
  typedef struct packed {
    logic             start;
    logic             eligible;
    logic [SlotW-1:0] slot;
  } match_ctl_t;

  typedef struct packed {
    logic                    busy;
    logic                    found;
    logic [SlotW-1:0]        slot;
    logic signed [TimeW-1:0] tm;
    logic [ResW-1:0]         resol;
  } match_res_t;

  // phi difference wrapped into [-pi, pi]; one step of 2 pi always suffices
  function automatic logic signed [PhiW-1:0] wrap_dphi(
    input logic signed [PhiW-1:0] a,
    input logic signed [PhiW-1:0] b
  );
    logic signed [PhiW+1:0] d;
    d = {{2{a[PhiW-1]}}, a} - {{2{b[PhiW-1]}}, b};
    if (d > PhiPi) begin
      d = d - PhiTwoPi;
    end else if (d < -PhiPi) begin
      d = d + PhiTwoPi;
    end
    return d[PhiW-1:0];
  endfunction

endpackage

[rtl/ntm_if.sv]
// valid/ready channel interfaces for query/load items and match results
// depends on ntm_pkg for field widths
interface ntm_in_if;
  import ntm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic signed [EtaW-1:0]  eta;
  logic signed [PhiW-1:0]  phi;
  logic signed [TimeW-1:0] in_time;
  logic [ResW-1:0]         in_resolution;

  modport source (output valid, output command, output eta, output phi,
                  output in_time, output in_resolution, input ready);
  modport sink (input valid, input command, input eta, input phi,
                input in_time, input in_resolution, output ready);
endinterface

interface ntm_out_if;
  import ntm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TimeW-1:0] out_time;
  logic [ResW-1:0]         out_resolution;
  logic                    found;
  logic [IndexW-1:0]       match_index;

  modport source (output valid, output out_time, output out_resolution,
                  output found, output match_index, input ready);
  modport sink (input valid, input out_time, input out_resolution,
                input found, input match_index, output ready);
endinterface

[rtl/ntm_cell.sv]
// one table cell: holds a reference entry, loads it or takes its neighbor's
// depends on ntm_pkg for the entry type
module ntm_cell (
  input  logic           clk,
  input  logic           load,
  input  logic           shift,
  input  ntm_pkg::entry_t load_data,
  input  ntm_pkg::entry_t next_data,
  output ntm_pkg::entry_t q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_data;
    end else if (shift) begin
      q <= next_data;
    end
  end

endmodule

[rtl/ntm_match.sv]
// distance unit at the head of the cell ring: difference, squares, running min
// depends on ntm_pkg for widths, types and the phi wrap function
module ntm_match (
  input  logic                         clk,
  input  logic                         rst,
  input  ntm_pkg::match_ctl_t          ctl,
  input  logic signed [ntm_pkg::EtaW-1:0] query_eta,
  input  logic signed [ntm_pkg::PhiW-1:0] query_phi,
  input  logic [ntm_pkg::MaxDistW-1:0] max_dist,
  input  ntm_pkg::entry_t              head,
  output ntm_pkg::match_res_t          res
);
  import ntm_pkg::*;

  logic signed [EtaW-1:0]  q_eta;
  logic signed [PhiW-1:0]  q_phi;

  // stage 1: differences
  logic                    s1_vld;
  logic signed [DeW-1:0]   s1_de;
  logic signed [PhiW-1:0]  s1_dp;
  logic [SlotW-1:0]        s1_slot;
  logic signed [TimeW-1:0] s1_tm;
  logic [ResW-1:0]         s1_res;

  // stage 2: squares
  logic                    s2_vld;
  logic [De2W-1:0]         s2_de2;
  logic [Dp2W-1:0]         s2_dp2;
  logic [SlotW-1:0]        s2_slot;
  logic signed [TimeW-1:0] s2_tm;
  logic [ResW-1:0]         s2_res;

  // running best
  logic [D2W-1:0]          best_d2;
  logic                    best_found;
  logic [SlotW-1:0]        best_slot;
  logic signed [TimeW-1:0] best_tm;
  logic [ResW-1:0]         best_res;

  logic signed [2*DeW-1:0]  de_sq;
  logic signed [2*PhiW-1:0] dp_sq;
  logic [D2W-1:0]           d2;

  always_comb begin
    de_sq = s1_de * s1_de;
    dp_sq = s1_dp * s1_dp;
    d2    = s2_de2 + D2W'(s2_dp2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      best_found <= 1'b0;
    end else begin
      s1_vld <= ctl.eligible;
      s2_vld <= s1_vld;
      if (ctl.start) begin
        best_found <= 1'b0;
      end else if (s2_vld && (d2 < best_d2)) begin
        best_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_eta <= query_eta;
      q_phi <= query_phi;
    end
    s1_de   <= {q_eta[EtaW-1], q_eta} - {head.eta[EtaW-1], head.eta};
    s1_dp   <= wrap_dphi(q_phi, head.phi);
    s1_slot <= ctl.slot;
    s1_tm   <= head.tm;
    s1_res  <= head.resol;

    s2_de2  <= de_sq[De2W-1:0];
    s2_dp2  <= dp_sq[Dp2W-1:0];
    s2_slot <= s1_slot;
    s2_tm   <= s1_tm;
    s2_res  <= s1_res;

    // strict compare keeps the earliest slot on ties
    if (ctl.start) begin
      best_d2   <= D2W'(max_dist);
      best_slot <= '0;
    end else if (s2_vld && (d2 < best_d2)) begin
      best_d2   <= d2;
      best_slot <= s2_slot;
      best_tm   <= s2_tm;
      best_res  <= s2_res;
    end
  end

  assign res.busy  = s1_vld | s2_vld;
  assign res.found = best_found;
  assign res.slot  = best_slot;
  assign res.tm    = best_tm;
  assign res.resol = best_res;

endmodule

[rtl/nearest_track_time_match.sv]
// top level: ring of reference-entry cells, scan sequencer, distance unit
// depends on ntm_pkg, ntm_if, ntm_cell and ntm_match
//
//   channel  dir  handshake            carries
//   in_ch    in   valid/ready          command, eta, phi, in_time, in_resolution
//   out_ch   out  valid/ready          out_time, out_resolution, found, match_index
//   cfg      in   cfg_we (no ready)    cfg_index, cfg_data
//
// clear and load items leave the sequencer idle; a load writes the cell at entry_count
// a query turns the cell ring once, one entry a cycle past the distance unit,
// then the two-stage pipe drains
// the result goes into an output register; the next item is taken while it waits,
// only a second query stalls at its end until the first result is taken
// synchronous reset clears count, sequencer and output valid and restores the config defaults; cells hold no reset
module nearest_track_time_match (
  input  logic                        clk,
  input  logic                        rst,
  ntm_in_if.sink                      in_ch,
  ntm_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [ntm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ntm_pkg::CfgW-1:0]    cfg_data
);
  import ntm_pkg::*;

  state_t state;
  state_t state_next;

  logic [CountW-1:0]   entry_count;
  logic [SlotW-1:0]    step;
  logic [MaxDistW-1:0] max_dist;
  logic [ResW-1:0]     def_res;

  logic                    out_valid;
  logic signed [TimeW-1:0] out_time;
  logic [ResW-1:0]         out_res;
  logic                    out_found;
  logic [IndexW-1:0]       out_index;

  logic       in_acc;
  logic       load_fire;
  logic       scan;
  logic       last_step;
  logic       out_free;
  logic       result_load;
  logic       in_ready;

  entry_t     cells [MaxEntries];
  entry_t     new_entry;
  match_ctl_t mctl;
  match_res_t mres;

  assign in_acc    = in_ch.valid && in_ready;
  assign load_fire = in_acc && (in_ch.command == CMD_LOAD) &&
                     (entry_count < CountW'(MaxEntries));
  assign last_step = (step == SlotW'(MaxEntries - 1));
  assign out_free  = !out_valid || out_ch.ready;

  assign new_entry.eta   = in_ch.eta;
  assign new_entry.phi   = in_ch.phi;
  assign new_entry.tm    = in_ch.in_time;
  assign new_entry.resol = in_ch.in_resolution;

  // ring: each cell passes its entry down, cell 0 wraps to the last
  for (genvar k = 0; k < MaxEntries; k++) begin : g_cell
    ntm_cell u_cell (
      .clk       (clk),
      .load      (load_fire && (entry_count == CountW'(k))),
      .shift     (scan),
      .load_data (new_entry),
      .next_data (cells[(k + 1) % MaxEntries]),
      .q         (cells[k])
    );
  end

  assign mctl.start    = in_acc && (in_ch.command == CMD_QUERY);
  assign mctl.eligible = scan && (CountW'(step) < entry_count);
  assign mctl.slot     = step;

  ntm_match u_match (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mctl),
    .query_eta (in_ch.eta),
    .query_phi (in_ch.phi),
    .max_dist  (max_dist),
    .head      (cells[0]),
    .res       (mres)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_ch.command == CMD_QUERY)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_step) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mres.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    scan        = 1'b0;
    result_load = 1'b0;
    case (state)
      ST_IDLE:  in_ready    = 1'b1;
      ST_SCAN:  scan        = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  result_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      step        <= '0;
      max_dist    <= MaxDistReset;
      def_res     <= DefResReset;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (in_acc && (in_ch.command == CMD_CLEAR)) begin
        entry_count <= '0;
      end else if (load_fire) begin
        entry_count <= entry_count + 1'b1;
      end

      if (scan) begin
        step <= last_step ? '0 : step + 1'b1;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_DIST: max_dist <= cfg_data[MaxDistW-1:0];
          CFG_DEF_RES:  def_res  <= cfg_data[ResW-1:0];
          default:      ;
        endcase
      end

      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      out_found <= mres.found;
      if (mres.found) begin
        out_time  <= mres.tm;
        out_res   <= mres.resol;
        out_index <= IndexW'(mres.slot);
      end else begin
        out_time  <= '0;
        out_res   <= def_res;
        out_index <= '0;
      end
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.out_time       = out_time;
  assign out_ch.out_resolution = out_res;
  assign out_ch.found          = out_found;
  assign out_ch.match_index    = out_index;

  // scan counter rests at zero between queries so the next turn starts at slot 0
  a_step_rest: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (step == '0))
    else $error("scan step not at rest outside scan");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (in_ch.command == CMD_LOAD) && (entry_count == CountW'(MaxEntries)))
      |=> (entry_count == CountW'(MaxEntries)))
    else $error("load into full table changed entry count");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> ((out_index == '0) && (out_time == '0)))
    else $error("unmatched result carries nonzero slot or time");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the done state");

endmodule
